/* rtl/caf_pkg.sv */
package caf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC_DEF   = 16;
  localparam int TBL_LEN          = 24;
  localparam int ANG_W            = 26;
  localparam int IN_W             = 176;
  localparam int OUT_W            = 80;
  localparam int PC_W             = 6;

  localparam logic [16:0] GYRO_WEIGHT_RST = 17'd62915;
  localparam logic [23:0] YAW_SNAP_RST    = 24'd11468800;

  localparam logic [1:0] REG_GYRO_WEIGHT = 2'd0;
  localparam logic [1:0] REG_YAW_SNAP    = 2'd1;

  typedef struct packed {
    logic [15:0] accel_x;
    logic [15:0] accel_y;
    logic [15:0] accel_z;
    logic [19:0] rate_x;
    logic [19:0] rate_y;
    logic [19:0] rate_z;
    logic [15:0] field_x;
    logic [15:0] field_y;
    logic [15:0] field_z;
    logic [15:0] step_time;
  } in_item_t;

  typedef struct packed {
    logic [25:0] roll_deg;
    logic [25:0] pitch_deg;
    logic [25:0] yaw_deg;
  } out_item_t;

  typedef struct packed {
    logic        wen;
    logic [1:0]  index;
    logic [23:0] data;
  } cfg_wr_t;

  typedef enum logic [3:0] {
    M_AXAX, M_AYAY, M_AZAZ, M_GXDT, M_GYDT, M_GZDT, M_WG, M_WANG,
    M_SPSR, M_SPCR, M_MZSR, M_MYCR, M_MXCP, M_MYP1, M_MZP2
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_RND
  } acc_op_t;

  typedef enum logic [2:0] {
    U_NONE, U_SQRT, U_VEC_ROLL, U_VEC_PITCH, U_VEC_HEAD, U_ROT_ROLL, U_ROT_PITCH
  } unit_t;

  typedef enum logic [3:0] {
    D_NONE, D_ANG, D_GROLL, D_GPITCH, D_GYAW, D_ROLL, D_PITCH, D_YAW,
    D_SCR, D_SCP, D_P1, D_P2, D_NUM, D_DEN
  } dest_t;

  typedef struct packed {
    logic     mul_en;
    mul_sel_t mul;
    acc_op_t  acc;
    unit_t    unit;
    dest_t    dest;
    logic     last;
  } uop_t;

  typedef struct packed {
    logic load_in;
    logic issue;
    logic publish;
    uop_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic unit_done;
  } dp_stat_t;

  typedef struct packed {
    logic        start;
    logic        rotate;
    logic [48:0] y;
    logic [48:0] x;
    logic [25:0] ang;
  } cordic_cmd_t;

  typedef struct packed {
    logic        done;
    logic [31:0] ang;
    logic [31:0] s;
    logic [31:0] c;
  } cordic_res_t;

  // atan(2^-i) in degrees, 20 fraction bits
  function automatic logic [31:0] atan_q20(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd47185920;
      5'd1:  v = 32'd27855475;
      5'd2:  v = 32'd14718068;
      5'd3:  v = 32'd7471121;
      5'd4:  v = 32'd3750058;
      5'd5:  v = 32'd1876857;
      5'd6:  v = 32'd938658;
      5'd7:  v = 32'd469357;
      5'd8:  v = 32'd234682;
      5'd9:  v = 32'd117342;
      5'd10: v = 32'd58671;
      5'd11: v = 32'd29335;
      5'd12: v = 32'd14668;
      5'd13: v = 32'd7334;
      5'd14: v = 32'd3667;
      5'd15: v = 32'd1833;
      5'd16: v = 32'd917;
      5'd17: v = 32'd458;
      5'd18: v = 32'd229;
      5'd19: v = 32'd115;
      5'd20: v = 32'd57;
      5'd21: v = 32'd29;
      5'd22: v = 32'd14;
      5'd23: v = 32'd7;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [25:0] sat26(input logic signed [67:0] v);
    logic [25:0] r;
    if (v > 68'sd33554431) begin
      r = 26'h1FFFFFF;
    end else if (v < -68'sd33554432) begin
      r = 26'h2000000;
    end else begin
      r = v[25:0];
    end
    return r;
  endfunction

  function automatic uop_t mk(input logic me, input mul_sel_t m, input acc_op_t a,
                              input unit_t u, input dest_t d, input logic l);
    uop_t o;
    o.mul_en = me;
    o.mul    = m;
    o.acc    = a;
    o.unit   = u;
    o.dest   = d;
    o.last   = l;
    return o;
  endfunction

  // microprogram: a product lands in p one op after it is selected
  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t o;
    unique case (pc)
      6'd0:  o = mk(1'b1, M_AXAX, ACC_HOLD, U_NONE,      D_NONE,   1'b0);
      6'd1:  o = mk(1'b1, M_AZAZ, ACC_LOAD, U_NONE,      D_NONE,   1'b0);
      6'd2:  o = mk(1'b0, M_AXAX, ACC_ADD,  U_NONE,      D_NONE,   1'b0);
      6'd3:  o = mk(1'b0, M_AXAX, ACC_HOLD, U_SQRT,      D_NONE,   1'b0);
      6'd4:  o = mk(1'b0, M_AXAX, ACC_HOLD, U_VEC_ROLL,  D_NONE,   1'b0);
      6'd5:  o = mk(1'b1, M_GXDT, ACC_HOLD, U_NONE,      D_ANG,    1'b0);
      6'd6:  o = mk(1'b0, M_AXAX, ACC_RND,  U_NONE,      D_GROLL,  1'b0);
      6'd7:  o = mk(1'b1, M_WG,   ACC_HOLD, U_NONE,      D_NONE,   1'b0);
      6'd8:  o = mk(1'b1, M_WANG, ACC_ADD,  U_NONE,      D_NONE,   1'b0);
      6'd9:  o = mk(1'b0, M_AXAX, ACC_ADD,  U_NONE,      D_NONE,   1'b0);
      6'd10: o = mk(1'b0, M_AXAX, ACC_HOLD, U_NONE,      D_ROLL,   1'b0);
      6'd11: o = mk(1'b1, M_AYAY, ACC_HOLD, U_NONE,      D_NONE,   1'b0);
      6'd12: o = mk(1'b1, M_AZAZ, ACC_LOAD, U_NONE,      D_NONE,   1'b0);
      6'd13: o = mk(1'b0, M_AXAX, ACC_ADD,  U_NONE,      D_NONE,   1'b0);
      6'd14: o = mk(1'b0, M_AXAX, ACC_HOLD, U_SQRT,      D_NONE,   1'b0);
      6'd15: o = mk(1'b0, M_AXAX, ACC_HOLD, U_VEC_PITCH, D_NONE,   1'b0);
      6'd16: o = mk(1'b1, M_GYDT, ACC_HOLD, U_NONE,      D_ANG,    1'b0);
      6'd17: o = mk(1'b0, M_AXAX, ACC_RND,  U_NONE,      D_GPITCH, 1'b0);
      6'd18: o = mk(1'b1, M_WG,   ACC_HOLD, U_NONE,      D_NONE,   1'b0);
      6'd19: o = mk(1'b1, M_WANG, ACC_ADD,  U_NONE,      D_NONE,   1'b0);
      6'd20: o = mk(1'b0, M_AXAX, ACC_ADD,  U_NONE,      D_NONE,   1'b0);
      6'd21: o = mk(1'b0, M_AXAX, ACC_HOLD, U_NONE,      D_PITCH,  1'b0);
      6'd22: o = mk(1'b0, M_AXAX, ACC_HOLD, U_ROT_ROLL,  D_NONE,   1'b0);
      6'd23: o = mk(1'b0, M_AXAX, ACC_HOLD, U_NONE,      D_SCR,    1'b0);
      6'd24: o = mk(1'b0, M_AXAX, ACC_HOLD, U_ROT_PITCH, D_NONE,   1'b0);
      6'd25: o = mk(1'b0, M_AXAX, ACC_HOLD, U_NONE,      D_SCP,    1'b0);
      6'd26: o = mk(1'b1, M_SPSR, ACC_HOLD, U_NONE,      D_NONE,   1'b0);
      6'd27: o = mk(1'b1, M_SPCR, ACC_HOLD, U_NONE,      D_P1,     1'b0);
      6'd28: o = mk(1'b1, M_MZSR, ACC_HOLD, U_NONE,      D_P2,     1'b0);
      6'd29: o = mk(1'b1, M_MYCR, ACC_LOAD, U_NONE,      D_NONE,   1'b0);
      6'd30: o = mk(1'b0, M_AXAX, ACC_SUB,  U_NONE,      D_NONE,   1'b0);
      6'd31: o = mk(1'b1, M_MXCP, ACC_HOLD, U_NONE,      D_NUM,    1'b0);
      6'd32: o = mk(1'b1, M_MYP1, ACC_LOAD, U_NONE,      D_NONE,   1'b0);
      6'd33: o = mk(1'b1, M_MZP2, ACC_ADD,  U_NONE,      D_NONE,   1'b0);
      6'd34: o = mk(1'b0, M_AXAX, ACC_ADD,  U_NONE,      D_NONE,   1'b0);
      6'd35: o = mk(1'b0, M_AXAX, ACC_HOLD, U_NONE,      D_DEN,    1'b0);
      6'd36: o = mk(1'b0, M_AXAX, ACC_HOLD, U_VEC_HEAD,  D_NONE,   1'b0);
      6'd37: o = mk(1'b1, M_GZDT, ACC_HOLD, U_NONE,      D_ANG,    1'b0);
      6'd38: o = mk(1'b0, M_AXAX, ACC_RND,  U_NONE,      D_GYAW,   1'b0);
      6'd39: o = mk(1'b1, M_WG,   ACC_HOLD, U_NONE,      D_NONE,   1'b0);
      6'd40: o = mk(1'b1, M_WANG, ACC_ADD,  U_NONE,      D_NONE,   1'b0);
      6'd41: o = mk(1'b0, M_AXAX, ACC_ADD,  U_NONE,      D_NONE,   1'b0);
      6'd42: o = mk(1'b0, M_AXAX, ACC_HOLD, U_NONE,      D_YAW,    1'b0);
      default: o = mk(1'b0, M_AXAX, ACC_HOLD, U_NONE,    D_NONE,   1'b1);
    endcase
    return o;
  endfunction

endpackage

/* rtl/caf_isqrt.sv */
module caf_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] value,
  output logic        done,
  output logic [23:0] root
);

  logic [47:0] rem;
  logic [47:0] res;
  logic [47:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [48:0] trial;

  assign trial = {1'b0, res} + {1'b0, bitv};
  assign root  = res[23:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one result bit per cycle, restoring form
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= value;
      res  <= '0;
      bitv <= 48'h4000_0000_0000;
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[47:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

/* rtl/caf_cordic.sv */
module caf_cordic #(
  parameter int CORDIC_STEPS    = caf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = caf_pkg::ANGLE_FRAC_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  caf_pkg::cordic_cmd_t cmd,
  output caf_pkg::cordic_res_t res
);

  localparam int NSTEP = (CORDIC_STEPS < caf_pkg::TBL_LEN) ? CORDIC_STEPS : caf_pkg::TBL_LEN;
  localparam int ZSH   = 20 - ANGLE_FRAC_BITS;
  localparam int MODK  = (ANGLE_FRAC_BITS >= 16) ? 0 : 16 - ANGLE_FRAC_BITS;
  localparam int RW0   = caf_pkg::ANG_W + ZSH + 2;
  localparam int RW    = (RW0 > 32) ? RW0 : 32;
  localparam int KW    = (MODK > 0) ? $clog2(MODK + 1) : 1;
  localparam logic [4:0]    ILAST  = 5'(NSTEP - 1);
  localparam logic [KW-1:0] KSTART = KW'(MODK);
  localparam logic [RW-1:0] DEG360U = RW'(377487360);
  localparam logic signed [31:0] DEG90  = 32'sd94371840;
  localparam logic signed [31:0] DEG180 = 32'sd188743680;
  localparam logic signed [31:0] DEG360 = 32'sd377487360;
  localparam logic signed [51:0] INV_GAIN = 52'sd652032874;

  typedef enum logic [5:0] {
    P_IDLE = 6'b000001,
    P_NORM = 6'b000010,
    P_PRE  = 6'b000100,
    P_MOD  = 6'b001000,
    P_FOLD = 6'b010000,
    P_ITER = 6'b100000
  } cordic_phase_t;

  cordic_phase_t phase;
  logic signed [51:0] x, y;
  logic signed [31:0] z;
  logic [RW-1:0]      r;
  logic               neg, flip;
  logic [4:0]         i;
  logic [KW-1:0]      k;
  logic               done;

  logic signed [51:0] x_in, y_in, dx, dy, ax, ay;
  logic signed [RW-1:0] za;
  logic [RW-1:0]      dk;
  logic signed [31:0] at, zm, zf1, zf2;
  logic               fl2;
  logic               lt32, lt40;

  assign x_in = 52'($signed(cmd.x));
  assign y_in = 52'($signed(cmd.y));
  assign za   = $signed(RW'($signed(cmd.ang))) <<< ZSH;
  assign dx   = y >>> i;
  assign dy   = x >>> i;
  assign at   = $signed(caf_pkg::atan_q20(i));
  assign ax   = x[51] ? -x : x;
  assign ay   = y[51] ? -y : y;
  assign lt32 = (ax[51:32] == '0) && (ay[51:32] == '0);
  assign lt40 = (ax[51:40] == '0) && (ay[51:40] == '0);
  assign dk   = DEG360U << k;

  // sign restore and range fold of the reduced angle
  always_comb begin
    zm = neg ? -$signed(r[31:0]) : $signed(r[31:0]);
    if (zm >= DEG180) begin
      zf1 = zm - DEG360;
    end else if (zm < -DEG180) begin
      zf1 = zm + DEG360;
    end else begin
      zf1 = zm;
    end
    fl2 = 1'b0;
    if (zf1 > DEG90) begin
      zf2 = zf1 - DEG180;
      fl2 = 1'b1;
    end else if (zf1 < -DEG90) begin
      zf2 = zf1 + DEG180;
      fl2 = 1'b1;
    end else begin
      zf2 = zf1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (cmd.start) begin
            if (cmd.rotate) begin
              phase <= P_MOD;
            end else if ((x_in == '0) && (y_in == '0)) begin
              done <= 1'b1;
            end else begin
              phase <= P_NORM;
            end
          end
        end
        P_NORM: if (!lt40) phase <= P_PRE;
        P_PRE:  phase <= P_ITER;
        P_MOD:  if (k == '0) phase <= P_FOLD;
        P_FOLD: phase <= P_ITER;
        P_ITER: begin
          if (i == ILAST) begin
            phase <= P_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase)
      P_IDLE: begin
        if (cmd.start) begin
          x    <= x_in;
          y    <= y_in;
          z    <= '0;
          i    <= '0;
          k    <= KSTART;
          flip <= 1'b0;
          neg  <= za[RW-1];
          r    <= za[RW-1] ? RW'(-za) : RW'(za);
        end
      end
      P_NORM: begin
        // bring the larger magnitude up to at least 2^40
        if (lt32) begin
          x <= x <<< 8;
          y <= y <<< 8;
        end else if (lt40) begin
          x <= x <<< 1;
          y <= y <<< 1;
        end
      end
      P_PRE: begin
        if (x < 0) begin
          if (y >= 0) begin
            x <= y;
            y <= -x;
            z <= DEG90;
          end else begin
            x <= -y;
            y <= x;
            z <= -DEG90;
          end
        end
      end
      P_MOD: begin
        if (r >= dk) r <= r - dk;
        k <= k - KW'(1);
      end
      P_FOLD: begin
        x    <= INV_GAIN;
        y    <= '0;
        z    <= zf2;
        flip <= fl2;
      end
      P_ITER: begin
        i <= i + 5'd1;
        if ((cmd.rotate && (z >= 0)) || (!cmd.rotate && (y < 0))) begin
          if (cmd.rotate) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - at;
          end else begin
            x <= x - dx;
            y <= y + dy;
            z <= z - at;
          end
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
      end
      default: ;
    endcase
  end

  logic signed [51:0] s_full, c_full;
  logic signed [31:0] z_sh;
  assign s_full = flip ? -y : y;
  assign c_full = flip ? -x : x;
  assign z_sh   = z >>> ZSH;

  assign res.done = done;
  assign res.ang  = z_sh;
  assign res.s    = s_full[31:0];
  assign res.c    = c_full[31:0];

endmodule

/* rtl/caf_datapath.sv */
module caf_datapath #(
  parameter int CORDIC_STEPS    = caf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = caf_pkg::ANGLE_FRAC_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  caf_pkg::dp_cmd_t    cmd,
  input  caf_pkg::in_item_t   in_item,
  input  caf_pkg::cfg_wr_t    cfg,
  output caf_pkg::dp_stat_t   stat,
  output caf_pkg::out_item_t  out_item
);

  localparam int GSH = 24 - ANGLE_FRAC_BITS;

  caf_pkg::in_item_t it;
  logic [16:0] gyro_weight;
  logic [23:0] yaw_snap_limit;
  logic signed [25:0] roll, pitch, yaw;
  logic signed [67:0] p, acc;
  logic signed [33:0] g;
  logic signed [31:0] ang, sr, cr, sp, cp, p1, p2;
  logic signed [48:0] num, den;

  logic signed [33:0] mul_a, mul_b;
  logic [16:0] w_eff, w_comp;
  logic signed [67:0] blend_sh, delta, ang_x;
  logic signed [33:0] lim_s, ang34;
  logic snap, sqrt_done;
  logic [23:0] root;
  logic signed [48:0] ay_s, ax_s;
  caf_pkg::cordic_cmd_t ccmd;
  caf_pkg::cordic_res_t cres;
  logic sqrt_start;

  assign w_eff  = (gyro_weight > 17'd65536) ? 17'd65536 : gyro_weight;
  assign w_comp = 17'd65536 - w_eff;

  always_comb begin
    unique case (cmd.op.mul)
      caf_pkg::M_AXAX: begin mul_a = 34'($signed(it.accel_x)); mul_b = mul_a; end
      caf_pkg::M_AYAY: begin mul_a = 34'($signed(it.accel_y)); mul_b = mul_a; end
      caf_pkg::M_AZAZ: begin mul_a = 34'($signed(it.accel_z)); mul_b = mul_a; end
      caf_pkg::M_GXDT: begin
        mul_a = 34'($signed(it.rate_x)); mul_b = $signed(34'(it.step_time));
      end
      caf_pkg::M_GYDT: begin
        mul_a = 34'($signed(it.rate_y)); mul_b = $signed(34'(it.step_time));
      end
      caf_pkg::M_GZDT: begin
        mul_a = 34'($signed(it.rate_z)); mul_b = $signed(34'(it.step_time));
      end
      caf_pkg::M_WG:   begin mul_a = $signed(34'(w_eff));  mul_b = g; end
      caf_pkg::M_WANG: begin mul_a = $signed(34'(w_comp)); mul_b = 34'(ang); end
      caf_pkg::M_SPSR: begin mul_a = 34'(sp); mul_b = 34'(sr); end
      caf_pkg::M_SPCR: begin mul_a = 34'(sp); mul_b = 34'(cr); end
      caf_pkg::M_MZSR: begin mul_a = 34'($signed(it.field_z)); mul_b = 34'(sr); end
      caf_pkg::M_MYCR: begin mul_a = 34'($signed(it.field_y)); mul_b = 34'(cr); end
      caf_pkg::M_MXCP: begin mul_a = 34'($signed(it.field_x)); mul_b = 34'(cp); end
      caf_pkg::M_MYP1: begin mul_a = 34'($signed(it.field_y)); mul_b = 34'(p1); end
      caf_pkg::M_MZP2: begin mul_a = 34'($signed(it.field_z)); mul_b = 34'(p2); end
      default:         begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign blend_sh = acc >>> 16;
  assign delta    = p >>> GSH;
  assign ang_x    = 68'(ang);
  assign ang34    = 34'(ang);
  assign lim_s    = $signed({10'b0, yaw_snap_limit});
  assign snap     = (ang34 > lim_s) || (ang34 < -lim_s);

  // sample, state and working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) it <= in_item;
    if (cmd.issue && cmd.op.mul_en) p <= mul_a * mul_b;
    if (cmd.issue) begin
      unique case (cmd.op.acc)
        caf_pkg::ACC_LOAD: acc <= p;
        caf_pkg::ACC_ADD:  acc <= acc + p;
        caf_pkg::ACC_SUB:  acc <= acc - p;
        caf_pkg::ACC_RND:  acc <= 68'sd32768;
        default:           ;
      endcase
      unique case (cmd.op.dest)
        caf_pkg::D_ANG:    ang <= $signed(cres.ang);
        caf_pkg::D_GROLL:  g   <= 34'(roll)  + delta[33:0];
        caf_pkg::D_GPITCH: g   <= 34'(pitch) + delta[33:0];
        caf_pkg::D_GYAW:   g   <= 34'(yaw)   + delta[33:0];
        caf_pkg::D_SCR:    begin sr <= $signed(cres.s); cr <= $signed(cres.c); end
        caf_pkg::D_SCP:    begin sp <= $signed(cres.s); cp <= $signed(cres.c); end
        caf_pkg::D_P1:     p1  <= 32'(p >>> 30);
        caf_pkg::D_P2:     p2  <= 32'(p >>> 30);
        caf_pkg::D_NUM:    num <= acc[48:0];
        caf_pkg::D_DEN:    den <= acc[48:0];
        default:           ;
      endcase
    end
    if (cmd.publish) begin
      out_item.roll_deg  <= roll;
      out_item.pitch_deg <= pitch;
      out_item.yaw_deg   <= yaw;
    end
  end

  // kept angles and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      roll           <= '0;
      pitch          <= '0;
      yaw            <= '0;
      gyro_weight    <= caf_pkg::GYRO_WEIGHT_RST;
      yaw_snap_limit <= caf_pkg::YAW_SNAP_RST;
    end else begin
      if (cfg.wen) begin
        priority if (cfg.index == caf_pkg::REG_GYRO_WEIGHT) begin
          gyro_weight <= cfg.data[16:0];
        end else if (cfg.index == caf_pkg::REG_YAW_SNAP) begin
          yaw_snap_limit <= cfg.data;
        end
      end
      if (cmd.issue) begin
        unique case (cmd.op.dest)
          caf_pkg::D_ROLL:  roll  <= caf_pkg::sat26(blend_sh);
          caf_pkg::D_PITCH: pitch <= caf_pkg::sat26(blend_sh);
          caf_pkg::D_YAW:   yaw   <= snap ? caf_pkg::sat26(ang_x) : caf_pkg::sat26(blend_sh);
          default:          ;
        endcase
      end
    end
  end

  assign sqrt_start = cmd.issue && (cmd.op.unit == caf_pkg::U_SQRT);

  caf_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value ({acc[31:0], 16'b0}),
    .done  (sqrt_done),
    .root  (root)
  );

  assign ay_s = 49'($signed(it.accel_y));
  assign ax_s = 49'($signed(it.accel_x));

  always_comb begin
    ccmd.start  = 1'b0;
    ccmd.rotate = 1'b0;
    ccmd.y      = '0;
    ccmd.x      = 49'(root);
    ccmd.ang    = roll;
    unique case (cmd.op.unit)
      caf_pkg::U_VEC_ROLL: begin
        ccmd.start = cmd.issue;
        ccmd.y     = ay_s <<< 8;
      end
      caf_pkg::U_VEC_PITCH: begin
        ccmd.start = cmd.issue;
        ccmd.y     = (-ax_s) <<< 8;
      end
      caf_pkg::U_VEC_HEAD: begin
        ccmd.start = cmd.issue;
        ccmd.y     = num;
        ccmd.x     = den;
      end
      caf_pkg::U_ROT_ROLL: begin
        ccmd.start  = cmd.issue;
        ccmd.rotate = 1'b1;
      end
      caf_pkg::U_ROT_PITCH: begin
        ccmd.start  = cmd.issue;
        ccmd.rotate = 1'b1;
        ccmd.ang    = pitch;
      end
      default: ;
    endcase
  end

  caf_cordic #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk (clk),
    .rst (rst),
    .cmd (ccmd),
    .res (cres)
  );

  assign stat.unit_done = sqrt_done | cres.done;

endmodule

/* rtl/caf_ctrl.sv */
module caf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  caf_pkg::dp_stat_t stat,
  output caf_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_WAIT = 3'b100
  } ctrl_state_t;

  localparam logic [caf_pkg::PC_W-1:0] PC_STEP = {{(caf_pkg::PC_W-1){1'b0}}, 1'b1};

  ctrl_state_t state;
  logic [caf_pkg::PC_W-1:0] pc;
  caf_pkg::uop_t op;
  logic can_pub;

  assign op       = caf_pkg::prog(pc);
  assign in_ready = (state == S_IDLE);
  assign can_pub  = !out_valid || out_ready;

  always_comb begin
    cmd.op      = op;
    cmd.load_in = in_valid && in_ready;
    cmd.issue   = (state == S_RUN) && !op.last;
    cmd.publish = (state == S_RUN) && op.last && can_pub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pc    <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (op.last) begin
            if (can_pub) begin
              state <= S_IDLE;
            end
          end else if (op.unit != caf_pkg::U_NONE) begin
            state <= S_WAIT;
          end else begin
            pc <= pc + PC_STEP;
          end
        end
        S_WAIT: begin
          if (stat.unit_done) begin
            pc    <= pc + PC_STEP;
            state <= S_RUN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/complementary_attitude_filter_unit.sv */
// complementary roll/pitch/yaw filter: each item is one sensor sample, and one result item
// comes back with the updated angles (degrees, 16 fraction bits, saturated to 26 bits).
// roll and pitch blend the gyro-integrated angle with accelerometer tilt; yaw blends with a
// tilt-compensated magnetometer heading, or takes that heading outright when it lies beyond
// the snap limit. one item is worked at a time, and the next item can go in from the
// cycle in which the result appears. the time is set by a microprogrammed sequencer
// driving one shared 34x34 multiplier (36 steps that wait on no unit, plus one publish
// step that waits for the output register to be free), a serial square root (run twice)
// and one shared iterative cordic: each sin/cos pass reduces and folds its angle, then
// iterates; each atan2 pass normalizes its input (up to 12 shifts), pre-rotates, then
// iterates; a zero vector skips these steps. a finished result waits in the output
// register while the next item is taken in. config writes (index 0 gyro weight, index 1
// yaw snap limit) are to go in while idle, a rule for the user the block does not enforce.
module complementary_attitude_filter_unit #(
  parameter int CORDIC_STEPS    = caf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = caf_pkg::ANGLE_FRAC_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, field_x, field_y, field_z,
  // step_time, zero pad
  input  logic [caf_pkg::IN_W-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // roll_deg, pitch_deg, yaw_deg, zero pad
  output logic [caf_pkg::OUT_W-1:0] m_tdata,
  input  logic                     cfg_wen,
  input  logic [1:0]               cfg_index,
  input  logic [23:0]              cfg_data
);

  caf_pkg::in_item_t  in_item;
  caf_pkg::out_item_t out_item;
  caf_pkg::cfg_wr_t   cfg;
  caf_pkg::dp_cmd_t   cmd;
  caf_pkg::dp_stat_t  stat;

  // unpack the stream word, lowest field first
  assign in_item.accel_x   = s_tdata[15:0];
  assign in_item.accel_y   = s_tdata[31:16];
  assign in_item.accel_z   = s_tdata[47:32];
  assign in_item.rate_x    = s_tdata[67:48];
  assign in_item.rate_y    = s_tdata[87:68];
  assign in_item.rate_z    = s_tdata[107:88];
  assign in_item.field_x   = s_tdata[123:108];
  assign in_item.field_y   = s_tdata[139:124];
  assign in_item.field_z   = s_tdata[155:140];
  assign in_item.step_time = s_tdata[171:156];

  assign cfg.wen   = cfg_wen;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // sequencer: walks the microprogram, waits on the iterative units
  caf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // multiplier, accumulator, square root, cordic and the kept angles
  caf_datapath #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg      (cfg),
    .stat     (stat),
    .out_item (out_item)
  );

  // result word, lowest field first
  assign m_tdata = {2'b00, out_item.yaw_deg, out_item.pitch_deg, out_item.roll_deg};

endmodule

/* rtl/caf_checker.sv */
module caf_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [caf_pkg::OUT_W-1:0] m_tdata
);

  // one item at a time: intake closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("intake stayed open after an accepted item");

  // a new result appears only as the sequencer returns to idle
  a_result_at_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready && !$past(s_tready))
    else $error("result raised outside the end of an item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind complementary_attitude_filter_unit caf_checker u_caf_checker (.*);
